// File: hdl/sctb_pkg.sv
// Shared types, constants and the square-root step for the coverage tint blend.
`timescale 1ns / 1ps

package sctb_pkg;

  // Pipeline depth from accepted input to the output register.
  localparam int unsigned NUM_STAGES = 8;

  // Channel geometry.
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned PIXEL_W  = CHAN_W * NUM_CHAN;

  // Full-scale channel value.
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // Reciprocal of 255 scaled by 2^24, used as floor((n + 1) * RECIP_255 / 2^24).
  localparam logic [16:0] RECIP_255 = 17'd65793;

  // Tint register value after reset.
  localparam logic [PIXEL_W-1:0] TINT_RESET = 24'hFFFFFF;

  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [15:0]           sq_t;
  typedef logic [23:0]           prod_t;
  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Partial root: t is the largest value found so far with t*t + t < lin,
  // and p holds t*t + t.
  typedef struct packed {
    chan_t t;
    sq_t   p;
  } root_t;

  // One digit of the root search: try setting bit b of t and keep it when
  // the trial still satisfies trial*trial + trial < lin.
  function automatic root_t root_step(root_t cur, sq_t lin, int unsigned b);
    root_t nxt;
    sq_t   tw;
    sq_t   trial;
    nxt   = cur;
    tw    = {8'd0, cur.t};
    trial = cur.p + (tw << (b + 1)) + (16'd1 << (2 * b)) + (16'd1 << b);
    if (trial < lin) begin
      nxt.t = cur.t | (8'd1 << b);
      nxt.p = trial;
    end
    return nxt;
  endfunction

endpackage

// File: hdl/sctb_chan.sv
// Pipelined datapath for one color channel of the coverage tint blend.
`timescale 1ns / 1ps

module sctb_chan (
  input  logic                clk,
  input  sctb_pkg::stage_en_t en,     // per-stage load enables
  input  sctb_pkg::chan_t     cov,    // coverage of this channel
  input  sctb_pkg::chan_t     bg,     // background of this channel
  input  sctb_pkg::chan_t     tint,   // tint of this channel
  output sctb_pkg::chan_t     blend   // blended channel, stage 7 register
);
  import sctb_pkg::*;

  sq_t          sq_bg;
  sq_t          sq_tint;
  chan_t        cov0;
  prod_t        prod_bg;
  prod_t        prod_tint;
  prod_t        num;
  logic [24:0]  num_inc;
  logic [41:0]  quot;
  sq_t          lin3;
  sq_t          lin4;
  sq_t          lin5;
  sq_t          lin6;
  root_t        root4;
  root_t        root5;
  root_t        root6;
  root_t        root7;
  root_t        step4;
  root_t        step5;
  root_t        step6;
  root_t        step7;
  chan_t        blend7;

  // Stage 0: square background and tint.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_bg   <= sq_t'(bg) * sq_t'(bg);
      sq_tint <= sq_t'(tint) * sq_t'(tint);
      cov0    <= cov;
    end
  end

  // Stage 1: weight each square by its coverage share.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_bg   <= prod_t'(sq_bg) * prod_t'(CHAN_MAX - cov0);
      prod_tint <= prod_t'(sq_tint) * prod_t'(cov0);
    end
  end

  // Stage 2: sum of the weighted squares, at most 255 * 65025.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      num <= prod_bg + prod_tint;
    end
  end

  // Stage 3: exact floor division by 255 through the scaled reciprocal.
  assign num_inc = 25'(num) + 25'd1;
  assign quot    = 42'(num_inc) * 42'(RECIP_255);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lin3 <= quot[39:24];
    end
  end

  // Stages 4 to 7: rounded square root, two digits per stage.
  assign step4 = root_step(root_t'('0), lin3, 7);
  assign step5 = root_step(root4, lin4, 5);
  assign step6 = root_step(root5, lin5, 3);
  assign step7 = root_step(root6, lin6, 1);
  assign root7 = root_step(step7, lin6, 0);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      root4 <= root_step(step4, lin3, 6);
      lin4  <= lin3;
    end
    if (en[5]) begin
      root5 <= root_step(step5, lin4, 4);
      lin5  <= lin4;
    end
    if (en[6]) begin
      root6 <= root_step(step6, lin5, 2);
      lin6  <= lin5;
    end
  end

  // The smallest r with r*r + r >= lin is one above the largest t below it.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      blend7 <= (lin6 == '0) ? chan_t'('0) : root7.t + chan_t'(1);
    end
  end

  assign blend = blend7;

endmodule

// File: hdl/subpixel_coverage_tint_blend.sv
// Top level of the subpixel coverage tint blend: handshake, tint register, valid pipeline.
`timescale 1ns / 1ps

// Blends the tint color over each background pixel with per-channel coverage, in
// gamma-2 linear light: lin = floor((d*d*(255-s) + c*c*s) / 255) and the result
// is the rounded root, the smallest r with r*r + r >= lin. The block takes one
// pixel per cycle while s_axis_tready is high; the pipeline depth is set by the
// square, weight, sum, divide-by-255 and four two-digit root stages. Each stage
// holds its own valid bit and loads whenever it is empty or its successor moves,
// so bubbles close up and a stalled output only holds back the stages behind it.
// Zero coverage returns the background channel and full coverage the tint channel
// exactly. The tint register resets to white and is written with cfg_we; the user
// must write it only while no pixel is in flight; the block does not enforce this.
module subpixel_coverage_tint_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  sctb_pkg::pixel_t     cfg_wdata,       // tint_color
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,    // coverage_pixel [23:0], background_pixel [47:24]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output sctb_pkg::pixel_t     m_axis_tdata     // blended_pixel [23:0]
);
  import sctb_pkg::*;

  pixel_t    tint_color;
  pixel_t    coverage_pixel;
  pixel_t    background_pixel;
  stage_en_t en;
  stage_en_t vld;

  assign coverage_pixel   = s_axis_tdata[PIXEL_W-1:0];
  assign background_pixel = s_axis_tdata[2*PIXEL_W-1:PIXEL_W];

  // Tint color register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_color <= TINT_RESET;
    end else if (cfg_we) begin
      tint_color <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // One datapath per color channel.
  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    sctb_chan u_chan (
      .clk   (clk),
      .en    (en),
      .cov   (coverage_pixel[ch*CHAN_W +: CHAN_W]),
      .bg    (background_pixel[ch*CHAN_W +: CHAN_W]),
      .tint  (tint_color[ch*CHAN_W +: CHAN_W]),
      .blend (m_axis_tdata[ch*CHAN_W +: CHAN_W])
    );
  end

  assign m_axis_tvalid = vld[NUM_STAGES-1];

  // A ready sink lets the whole pipeline advance, so the input is ready too.
  a_ready_through : assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while the output sink is ready");

  // An empty output stage never blocks the input.
  a_empty_out_ready : assert property (@(posedge clk) disable iff (rst)
    !vld[NUM_STAGES-1] |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // An accepted transaction occupies the first stage in the next cycle.
  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted transaction missing from the first stage");

endmodule

// File: bench/subpixel_coverage_tint_blend_test.sv
// Self-checking bench for the coverage tint blend: stream stimulus, prediction and result checks.
`timescale 1ns / 1ps

module subpixel_coverage_tint_blend_test;
  import sctb_pkg::*;

  // Cycle budget for the whole run, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PIXELS = 1600;
  localparam int unsigned NUM_PHASES = 6;

  // One pixel in flight: its inputs and the blend we expect back.
  typedef struct {
    pixel_t coverage;
    pixel_t background;
    pixel_t blended;
  } blend_entry_t;

  // Keeps its own tint copy, predicts each accepted pixel and checks results in order.
  class tint_blend_scoreboard;
    pixel_t       tint;
    blend_entry_t in_flight[$];
    int unsigned  mismatches;

    function new();
      tint       = TINT_RESET;
      mismatches = 0;
    endfunction

    // Gamma-2 blend of one channel, then the rounded square root.
    function chan_t blend_channel(chan_t s, chan_t d, chan_t c);
      int unsigned lin;
      int unsigned r;
      lin = (int'(d) * int'(d) * (255 - int'(s)) + int'(c) * int'(c) * int'(s)) / 255;
      r   = 0;
      while (r < 255 && r * r + r < lin) r++;
      return chan_t'(r);
    endfunction

    function pixel_t blend_pixel(pixel_t cov, pixel_t bg);
      pixel_t res;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        res[ch*CHAN_W +: CHAN_W] = blend_channel(cov[ch*CHAN_W +: CHAN_W],
                                                 bg[ch*CHAN_W +: CHAN_W],
                                                 tint[ch*CHAN_W +: CHAN_W]);
      end
      return res;
    endfunction

    // Called for every accepted input transaction.
    function void note_pixel(pixel_t cov, pixel_t bg);
      blend_entry_t e;
      e.coverage   = cov;
      e.background = bg;
      e.blended    = blend_pixel(cov, bg);
      in_flight.push_back(e);
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Called for every accepted output transaction.
    task check_blended(pixel_t got);
      blend_entry_t e;
      if (in_flight.size() == 0) begin
        report_mismatch($sformatf("unexpected output pixel %06h", got));
      end else begin
        e = in_flight.pop_front();
        if (got !== e.blended)
          report_mismatch($sformatf("cov %06h bg %06h tint %06h: blended %06h, want %06h",
                                    e.coverage, e.background, tint, got, e.blended));
      end
    endtask

    function int unsigned pending();
      return in_flight.size();
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   cfg_we;
  pixel_t cfg_wdata;
  logic   s_axis_tvalid;
  logic   s_axis_tready;
  logic [47:0] s_axis_tdata;     // coverage_pixel [23:0], background_pixel [47:24]
  logic   m_axis_tvalid;
  logic   m_axis_tready;
  pixel_t m_axis_tdata;          // blended_pixel [23:0]

  tint_blend_scoreboard blend_sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  subpixel_coverage_tint_blend u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock; the first rising edge comes at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output monitor: every accepted output transaction is checked.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) blend_sb.check_blended(m_axis_tdata);
  end

  // Channel values lean toward the extremes now and then.
  function automatic chan_t random_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return chan_t'($urandom_range(1, 0) ? 8'h01 : 8'hFE);
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    return {random_channel(), random_channel(), random_channel()};
  endfunction

  // Sends one pixel; called and returns at a falling edge.
  task automatic send_pixel(input pixel_t cov, input pixel_t bg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bg, cov};
    do @(posedge clk); while (!s_axis_tready);
    blend_sb.note_pixel(cov, bg);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (blend_sb.pending() != 0);
  endtask

  // Tint writes happen only with the pipeline empty.
  task automatic write_tint(input pixel_t value);
    drain_pipeline();
    repeat (NUM_STAGES + 2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    blend_sb.tint = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    pixel_t tint_setting;
    int unsigned per_phase;

    blend_sb       = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pixels with the reset tint (white).
    send_pixel(24'h000000, 24'h000000);
    send_pixel(24'h000000, 24'hFFFFFF);
    send_pixel(24'hFFFFFF, 24'h000000);
    send_pixel(24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'h000000, 24'h123456);
    send_pixel(24'hFFFFFF, 24'hABCDEF);
    send_pixel(24'h00FF80, 24'h123456);
    send_pixel(24'h800080, 24'hFF00FF);
    send_pixel(24'h010101, 24'hFEFEFE);
    send_pixel(24'hFEFEFE, 24'h010101);
    send_pixel(24'h7F7F7F, 24'h000000);
    send_pixel(24'h0000FF, 24'hA5A5A5);

    // Directed pixels with a black tint and then a mixed one.
    write_tint(24'h000000);
    send_pixel(24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'h000000, 24'hFFFFFF);
    send_pixel(24'h7F7F7F, 24'hFFFFFF);
    send_pixel(24'h808080, 24'h5A5A5A);
    send_pixel(24'hFF0000, 24'h00FF00);
    write_tint(24'hFF8001);
    send_pixel(24'hFFFFFF, 24'h000000);
    send_pixel(24'h000000, 24'h3C3C3C);
    send_pixel(24'h808080, 24'h7FFF00);
    send_pixel(24'h01FE7F, 24'hFE01FF);
    send_pixel(24'hFF00FF, 24'h00FF00);

    // Random phases: each sets a tint and one of four idling patterns.
    per_phase = RANDOM_PIXELS / NUM_PHASES;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: tint_setting = 24'h000000;
        1: tint_setting = 24'hFFFFFF;
        default: tint_setting = random_pixel();
      endcase
      write_tint(tint_setting);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        // Once, halfway through a stalled phase, let the block empty out completely.
        if (phase == 2 && n == per_phase / 2) drain_pipeline();
        send_pixel(random_pixel(), random_pixel());
      end
    end

    // Wind down: collect every result, then watch for strays.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_pipeline();
    repeat (2 * NUM_STAGES) @(negedge clk);
    while (blend_sb.pending() != 0) begin
      blend_sb.report_mismatch($sformatf("missing output for cov %06h bg %06h",
                                         blend_sb.in_flight[0].coverage,
                                         blend_sb.in_flight[0].background));
      void'(blend_sb.in_flight.pop_front());
    end

    if (blend_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sctb_pkg.sv
hdl/sctb_chan.sv
hdl/subpixel_coverage_tint_blend.sv
bench/subpixel_coverage_tint_blend_test.sv
